@@ rtl/core/stream_delimiter_matcher_top_macros.svh @@
// assertion macros for the stream delimiter matcher
// used by stream_delimiter_matcher_top; no other dependencies
`ifndef STREAM_DELIMITER_MATCHER_TOP_MACROS_SVH
`define STREAM_DELIMITER_MATCHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition that holds at every clock edge out of reset
`define SDM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SDM_ASSERT_ALWAYS(label, cond, msg)
`define SDM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/sdm_pkg.sv @@
// shared types, constants and helpers for the stream delimiter matcher
// no dependencies
package sdm_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned PatLenW    = 5;
  localparam int unsigned PatIdxW    = $clog2(MaxPattern);
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [CountW-1:0]  MaxLenReset = 32'd65536;
  localparam logic [PatLenW-1:0] PatLenReset = 5'd1;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_PAT_LEN  = 3'd2,
    REG_MAX_LEN  = 3'd3
  } sdm_reg_e;

  // why a message ended
  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_DELIM = 2'd1,
    CAUSE_LIMIT = 2'd2
  } sdm_cause_e;

  // status from the byte counter to the top level
  typedef struct packed {
    logic pat_covered;  // message holds at least the delimiter length
    logic limit_hit;    // message reaches the length limit with this byte
  } sdm_cnt_stat_t;

  // delimiter byte number idx, byte 0 first to arrive
  function automatic logic [7:0] pattern_byte(input logic [CfgDataW-1:0] low,
                                              input logic [CfgDataW-1:0] high,
                                              input logic [PatIdxW-1:0]  idx);
    logic [CfgDataW-1:0] word;
    word = idx[PatIdxW-1] ? high : low;
    return word[{idx[PatIdxW-2:0], 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/core/stream_delimiter_matcher_top.sv @@
// channel     | valid        | stall        | payload
// byte in     | data_valid_i | data_stall_o | data_byte_i
// result out  | out_valid_o  | out_stall_i  | out_byte_o, last_o, end_cause_o
// config      | cfg_we_i     | none         | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle while the output is not stalled; a result shows up in the cycle after its transfer in.
// the window is a row of 16 cells, which all compare in parallel.
// reset empties the window and zeroes the count; no clearing pass is needed.
// a stalled result holds the output register; a new byte is taken in the same
// cycle the waiting result leaves.
// depends on sdm_pkg, sdm_cell, sdm_count and the assertion macro header
`include "stream_delimiter_matcher_top_macros.svh"

module stream_delimiter_matcher_top import sdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // byte input
  input  logic                data_valid_i,
  output logic                data_stall_o,
  input  logic [7:0]          data_byte_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o,
  output logic [1:0]          end_cause_o
);

  logic [CfgDataW-1:0] pat_low_q;
  logic [CfgDataW-1:0] pat_high_q;
  logic [PatLenW-1:0]  pat_len_q;
  logic [CountW-1:0]   max_len_q;
  logic [PatLenW-1:0]  pat_len_eff;

  logic                in_fire;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  sdm_cause_e          cause_q, cause_d;

  logic [7:0]          win_in   [MaxPattern];
  logic [7:0]          win_byte [MaxPattern];
  logic [MaxPattern-1:0] hit;
  sdm_cnt_stat_t       cnt_stat;
  logic [CountW-1:0]   count;
  logic                msg_end;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= PatLenReset;
      max_len_q  <= MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        REG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_wdata_i[PatLenW-1:0];
        REG_MAX_LEN:  max_len_q  <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // delimiter length clamped to the window depth
  assign pat_len_eff = (pat_len_q > PatLenW'(MaxPattern)) ? PatLenW'(MaxPattern) : pat_len_q;

  // take a byte whenever the output register is free or being emptied
  assign data_stall_o = out_valid_q && out_stall_i;
  assign in_fire      = data_valid_i && !data_stall_o;

  // window: cell 0 takes the new byte, cell k takes cell k-1
  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic                active;
    logic [PatIdxW-1:0]  pat_idx;
    logic [PatLenW-1:0]  pat_pos;

    if (k == 0) begin : g_head
      assign win_in[k] = data_byte_i;
    end else begin : g_link
      assign win_in[k] = win_byte[k-1];
    end

    // cell k sees delimiter byte len-1-k when it lies within the delimiter
    assign active  = (PatLenW'(k) < pat_len_eff);
    assign pat_pos = pat_len_eff - PatLenW'(k + 1);
    assign pat_idx = pat_pos[PatIdxW-1:0];

    sdm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (in_fire),
      .clear_i  (msg_end),
      .byte_i   (win_in[k]),
      .pat_i    (pattern_byte(pat_low_q, pat_high_q, pat_idx)),
      .active_i (active),
      .byte_o   (win_byte[k]),
      .hit_o    (hit[k])
    );
  end

  sdm_count u_count (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_fire),
    .clear_i   (msg_end),
    .pat_len_i (pat_len_eff),
    .max_len_i (max_len_q),
    .stat_o    (cnt_stat),
    .count_o   (count)
  );

  // delimiter wins over the length limit
  always_comb begin
    if (cnt_stat.pat_covered && (&hit)) begin
      cause_d = CAUSE_DELIM;
    end else if (cnt_stat.limit_hit) begin
      cause_d = CAUSE_LIMIT;
    end else begin
      cause_d = CAUSE_NONE;
    end
  end

  assign msg_end = (cause_d != CAUSE_NONE);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= data_byte_i;
      cause_q    <= cause_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign end_cause_o = cause_q;
  assign last_o      = (cause_q != CAUSE_NONE);

  // checks
  `SDM_ASSERT_ALWAYS(a_cause_code, !out_valid_q || (cause_q == CAUSE_NONE) || (cause_q == CAUSE_DELIM) || (cause_q == CAUSE_LIMIT), "bad end cause on output")
  `SDM_ASSERT_NEXT(a_end_clears_count, in_fire && msg_end, count == '0, "count not cleared after message end")
  `SDM_ASSERT_NEXT(a_end_clears_window, in_fire && msg_end, win_byte[0] == 8'h00, "window not cleared after message end")
  `SDM_ASSERT_NEXT(a_stall_holds_result, out_valid_q && out_stall_i, out_valid_q && $stable(out_byte_q) && $stable(cause_q), "stalled result changed")

endmodule

@@ rtl/core/sdm_cell.sv @@
// one window cell: holds one byte of the message history and compares it
// depends on sdm_pkg
module sdm_cell import sdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;

  // the byte this cell takes on a transfer must equal its delimiter byte
  assign hit_o = !active_i || (byte_i == pat_i);

  // shift in from the neighbor, or empty the cell when a message ends
  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = clear_i ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

@@ rtl/core/sdm_count.sv @@
// message byte counter with saturation and limit compare
// depends on sdm_pkg
module sdm_count import sdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                clear_i,
  input  logic [PatLenW-1:0]  pat_len_i,
  input  logic [CountW-1:0]   max_len_i,
  output sdm_cnt_stat_t       stat_o,
  output logic [CountW-1:0]   count_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] max_eff;

  // count including the byte on offer, held at all ones
  assign count_inc = (count_q == {CountW{1'b1}}) ? count_q : count_q + 1'b1;

  // a zero limit acts as one
  assign max_eff = (max_len_i == '0) ? {{(CountW-1){1'b0}}, 1'b1} : max_len_i;

  assign stat_o.pat_covered = (pat_len_i != '0) &&
                              (count_inc >= {{(CountW-PatLenW){1'b0}}, pat_len_i});
  assign stat_o.limit_hit   = (count_inc >= max_eff);

  always_comb begin
    count_d = count_q;
    if (step_i) begin
      count_d = clear_i ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule
